// ===== hdl/cpdm_pkg.sv =====
// shared constants, codes and the packet record for the packet drive mixer
`timescale 1ns / 1ps

package cpdm_pkg;

   // fixed point format of the wheel speeds
   localparam int FRAC_BITS = 12;
   localparam int FIX_W     = FRAC_BITS + 4;   // converted float, [-8.0, 8.0)
   localparam int MIX_W     = FRAC_BITS + 6;   // headroom for the mixing sums
   localparam int SPD_W     = 14;              // wheel speed port width
   localparam int THR_W     = 13;
   localparam int RANGE_W   = 16;

   // float exponent bounds: at or above SAT_EXP the value saturates,
   // at or below ZERO_EXP it truncates to zero
   localparam int SAT_EXP  = 127 + 23 - FRAC_BITS;
   localparam int ZERO_EXP = SAT_EXP - 24;

   // framing bytes
   localparam logic [7:0] START_BYTE  = 8'h21;   // '!'
   localparam logic [7:0] MODE_TILT   = 8'h41;   // 'A'
   localparam logic [7:0] MODE_BUTTON = 8'h42;   // 'B'
   localparam logic [7:0] PRESS_BYTE  = 8'h31;   // '1'

   // button numbers
   localparam logic [7:0] BTN_FORWARD = 8'h35;   // '5'
   localparam logic [7:0] BTN_REVERSE = 8'h36;   // '6'
   localparam logic [7:0] BTN_LEFT    = 8'h37;   // '7'
   localparam logic [7:0] BTN_RIGHT   = 8'h38;   // '8'

   // register indexes
   localparam logic CSR_TILT_THRESHOLD = 1'b0;
   localparam logic CSR_OBSTACLE_LIMIT = 1'b1;

   // request kinds
   localparam logic REQ_SERIAL_BYTE = 1'b0;
   localparam logic REQ_RANGE       = 1'b1;

   // a checked packet handed from the parser to the mixer
   typedef struct packed {
      logic                is_tilt;
      logic [31:0]         tilt_x;
      logic [31:0]         tilt_y;
      logic [7:0]          button_number;
      logic [7:0]          button_state;
      logic [RANGE_W-1:0]  latched_range;
   } packet_type;

endpackage

// ===== hdl/cpdm_parser.sv =====
// serial packet framing, checksum and packet register
`timescale 1ns / 1ps

module cpdm_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_accept,
   input  logic                 item_type,
   input  logic [7:0]           item_byte,
   input  logic [15:0]          item_range,
   input  logic                 pkt_take,
   output logic                 pkt_valid,
   output cpdm_pkg::packet_type pkt
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_MODE   = 3'd1;
   localparam logic [2:0] PH_TILT   = 3'd2;
   localparam logic [2:0] PH_BUTTON = 3'd3;
   localparam logic [2:0] PH_CHECK  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  mode_ff, mode_in;
   logic [31:0] tilt_x_ff, tilt_x_in;
   logic [31:0] tilt_y_ff, tilt_y_in;
   logic [7:0]  btn_num_ff, btn_num_in;
   logic [7:0]  btn_state_ff, btn_state_in;
   logic [15:0] cur_range_ff, cur_range_in;
   logic [15:0] lat_range_ff, lat_range_in;
   logic        pkt_valid_ff, pkt_valid_in;
   cpdm_pkg::packet_type pkt_ff, pkt_in;
   logic        emit;
   logic [3:0]  count_inc;
   logic [4:0]  lane_shift;
   logic [31:0] lane_mask;
   logic [31:0] lane_data;

   assign count_inc  = count_ff + 4'd1;
   assign lane_shift = {count_ff[1:0], 3'b000};
   assign lane_mask  = ~(32'h0000_00FF << lane_shift);
   assign lane_data  = {24'd0, item_byte} << lane_shift;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      mode_in      = mode_ff;
      tilt_x_in    = tilt_x_ff;
      tilt_y_in    = tilt_y_ff;
      btn_num_in   = btn_num_ff;
      btn_state_in = btn_state_ff;
      cur_range_in = cur_range_ff;
      lat_range_in = lat_range_ff;
      emit         = 1'b0;
      if (item_accept) begin
         if (item_type == cpdm_pkg::REQ_RANGE) begin
            cur_range_in = item_range;
         end else begin
            case (phase_ff)
               PH_MODE: begin
                  mode_in  = item_byte;
                  sum_in   = sum_ff + item_byte;
                  count_in = 4'd0;
                  if (item_byte == cpdm_pkg::MODE_TILT) begin
                     phase_in = PH_TILT;
                  end else if (item_byte == cpdm_pkg::MODE_BUTTON) begin
                     phase_in = PH_BUTTON;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_TILT: begin
                  sum_in = sum_ff + item_byte;
                  if (count_ff < 4'd4) begin
                     tilt_x_in = (tilt_x_ff & lane_mask) | lane_data;
                  end else if (count_ff < 4'd8) begin
                     tilt_y_in = (tilt_y_ff & lane_mask) | lane_data;
                  end
                  count_in = count_inc;
                  if (count_inc >= 4'd12) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_BUTTON: begin
                  sum_in = sum_ff + item_byte;
                  if (count_ff == 4'd0) begin
                     btn_num_in = item_byte;
                     count_in   = 4'd1;
                  end else begin
                     btn_state_in = item_byte;
                     count_in     = 4'd2;
                     phase_in     = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  phase_in = PH_IDLE;
                  emit     = (item_byte == ~sum_ff);
               end
               default: begin
                  phase_in = PH_IDLE;
                  if (item_byte == cpdm_pkg::START_BYTE) begin
                     lat_range_in = cur_range_ff;
                     sum_in       = item_byte;
                     count_in     = 4'd0;
                     phase_in     = PH_MODE;
                  end
               end
            endcase
         end
      end
   end

   // packet register: loads on a good check byte, empties when the mixer takes it
   always_comb begin
      pkt_valid_in = pkt_valid_ff;
      pkt_in       = pkt_ff;
      if (emit) begin
         pkt_valid_in         = 1'b1;
         pkt_in.is_tilt       = (mode_ff == cpdm_pkg::MODE_TILT);
         pkt_in.tilt_x        = tilt_x_ff;
         pkt_in.tilt_y        = tilt_y_ff;
         pkt_in.button_number = btn_num_ff;
         pkt_in.button_state  = btn_state_ff;
         pkt_in.latched_range = lat_range_ff;
      end else if (pkt_take) begin
         pkt_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 4'd0;
         sum_ff       <= 8'd0;
         mode_ff      <= 8'd0;
         tilt_x_ff    <= 32'd0;
         tilt_y_ff    <= 32'd0;
         btn_num_ff   <= 8'd0;
         btn_state_ff <= 8'd0;
         cur_range_ff <= 16'd0;
         lat_range_ff <= 16'd0;
         pkt_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         mode_ff      <= mode_in;
         tilt_x_ff    <= tilt_x_in;
         tilt_y_ff    <= tilt_y_in;
         btn_num_ff   <= btn_num_in;
         btn_state_ff <= btn_state_in;
         cur_range_ff <= cur_range_in;
         lat_range_ff <= lat_range_in;
         pkt_valid_ff <= pkt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;

endmodule

// ===== hdl/cpdm_float_to_fixed.sv =====
// single precision float to saturating fixed point, truncating toward zero
`timescale 1ns / 1ps

module cpdm_float_to_fixed (
   input  logic [31:0]                        float_bits,
   output logic signed [cpdm_pkg::FIX_W-1:0]  fixed
);

   localparam logic [23:0] LIMIT = 24'(1 << (cpdm_pkg::FRAC_BITS + 3));

   logic        sign;
   logic [7:0]  expo;
   logic [23:0] mant;
   logic [7:0]  exp_diff;
   logic [23:0] mag;
   logic signed [cpdm_pkg::FIX_W-1:0] mag_fix;
   logic signed [cpdm_pkg::FIX_W-1:0] sat_val;

   assign sign     = float_bits[31];
   assign expo     = float_bits[30:23];
   assign mant     = {1'b1, float_bits[22:0]};
   assign exp_diff = 8'(cpdm_pkg::SAT_EXP) - expo;
   assign mag      = mant >> exp_diff[4:0];
   assign mag_fix  = cpdm_pkg::FIX_W'(mag);
   // most negative code for sign set, most positive otherwise
   assign sat_val  = sign ? {1'b1, {(cpdm_pkg::FIX_W-1){1'b0}}}
                          : {1'b0, {(cpdm_pkg::FIX_W-1){1'b1}}};

   always_comb begin
      if (expo >= 8'(cpdm_pkg::SAT_EXP)) begin
         fixed = sat_val;
      end else if (expo <= 8'(cpdm_pkg::ZERO_EXP)) begin
         fixed = '0;
      end else if (mag >= LIMIT) begin
         fixed = sat_val;
      end else begin
         fixed = sign ? -mag_fix : mag_fix;
      end
   end

endmodule

// ===== hdl/cpdm_mixer.sv =====
// tilt and button mixing into wheel speeds, with the result register
`timescale 1ns / 1ps

module cpdm_mixer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pkt_valid,
   input  cpdm_pkg::packet_type               pkt,
   input  logic [cpdm_pkg::THR_W-1:0]         tilt_threshold,
   input  logic [cpdm_pkg::RANGE_W-1:0]       obstacle_limit,
   output logic                               pkt_take,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cpdm_pkg::SPD_W-1:0]  left_speed,
   output logic signed [cpdm_pkg::SPD_W-1:0]  right_speed,
   output logic                               source,
   output logic                               obstacle_stop
);

   localparam int MW = cpdm_pkg::MIX_W;
   localparam int FW = cpdm_pkg::FIX_W;
   localparam logic signed [MW-1:0] ONE = MW'(1 << cpdm_pkg::FRAC_BITS);

   logic signed [FW-1:0] x_fix, y_fix;
   logic signed [MW-1:0] xs, ys, th, h;
   logic signed [MW-1:0] tl, tr, bl, br, ml, mr, cl, cr;
   logic                 blocked, pressed, x_fwd, x_back, y_on;
   logic                 t_stop, b_stop, b_known, mix_ok;
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [cpdm_pkg::SPD_W-1:0] left_ff, left_in, right_ff, right_in;
   logic                 source_ff, source_in, stop_ff, stop_in;

   cpdm_float_to_fixed u_conv_x (.float_bits(pkt.tilt_x), .fixed(x_fix));
   cpdm_float_to_fixed u_conv_y (.float_bits(pkt.tilt_y), .fixed(y_fix));

   assign xs = {{(MW-FW){x_fix[FW-1]}}, x_fix};
   assign ys = {{(MW-FW){y_fix[FW-1]}}, y_fix};
   assign th = {{(MW-cpdm_pkg::THR_W){1'b0}}, tilt_threshold};
   // halve toward zero
   assign h  = $signed(ys + MW'(ys[MW-1])) >>> 1;

   assign blocked = (pkt.latched_range != '0) && (pkt.latched_range < obstacle_limit);
   assign x_back  = xs < -th;
   assign x_fwd   = xs > th;
   assign y_on    = (ys > th) || (ys < -th);

   // tilt path
   always_comb begin
      tl     = '0;
      tr     = '0;
      t_stop = 1'b0;
      if (x_back) begin
         if (blocked) begin
            t_stop = 1'b1;
         end else begin
            tl = xs;
            tr = -xs;
         end
      end else if (x_fwd) begin
         tl = xs;
         tr = -xs;
      end
      ml = tl;
      mr = tr;
      if (y_on) begin
         if (x_fwd) begin
            ml = tl + h;
            mr = tr + h;
         end else begin
            ml = tl - h;
            mr = tr - h;
         end
      end
      cl = (ml > ONE) ? ONE : ((ml < -ONE) ? -ONE : ml);
      cr = (mr > ONE) ? ONE : ((mr < -ONE) ? -ONE : mr);
   end

   // button path
   assign pressed = (pkt.button_state == cpdm_pkg::PRESS_BYTE);

   always_comb begin
      bl      = '0;
      br      = '0;
      b_stop  = 1'b0;
      b_known = 1'b1;
      case (pkt.button_number)
         cpdm_pkg::BTN_FORWARD: begin
            if (pressed) begin
               if (blocked) begin
                  b_stop = 1'b1;
               end else begin
                  bl = -ONE;
                  br = ONE;
               end
            end
         end
         cpdm_pkg::BTN_REVERSE: begin
            if (pressed) begin
               bl = ONE;
               br = -ONE;
            end
         end
         cpdm_pkg::BTN_LEFT: begin
            if (pressed) begin
               bl = -ONE;
            end
         end
         cpdm_pkg::BTN_RIGHT: begin
            if (pressed) begin
               br = ONE;
            end
         end
         default: begin
            b_known = 1'b0;
         end
      endcase
   end

   assign mix_ok   = pkt.is_tilt || b_known;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pkt_take = out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      source_in    = source_ff;
      stop_in      = stop_ff;
      if (out_free) begin
         rsp_valid_in = pkt_valid && mix_ok;
         if (pkt.is_tilt) begin
            left_in   = cl[cpdm_pkg::SPD_W-1:0];
            right_in  = cr[cpdm_pkg::SPD_W-1:0];
            source_in = 1'b0;
            stop_in   = t_stop;
         end else begin
            left_in   = bl[cpdm_pkg::SPD_W-1:0];
            right_in  = br[cpdm_pkg::SPD_W-1:0];
            source_in = 1'b1;
            stop_in   = b_stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      source_ff <= source_in;
      stop_ff   <= stop_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign left_speed    = left_ff;
   assign right_speed   = right_ff;
   assign source        = source_ff;
   assign obstacle_stop = stop_ff;

endmodule

// ===== hdl/controller_packet_drive_mixer_unit.sv =====
// top level of the packet drive mixer: csr registers, parser and mixer
// the packet register loads at the edge that takes the check byte, and the result register
// loads from it through the mixer once the result output is free
// throughput: one item per cycle while the packet register is free or moves on, set by the packet and result registers
// an item is taken while a result waits, as long as the packet register is free
// reset: synchronous, clears the parser, both valids and restores the csr defaults
`timescale 1ns / 1ps

module controller_packet_drive_mixer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [7:0]                        req_data_byte,
   input  logic [15:0]                       req_range_mm,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [13:0]                rsp_left_speed,
   output logic signed [13:0]                rsp_right_speed,
   output logic                              rsp_source,
   output logic                              rsp_obstacle_stop,
   // csr writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [15:0]                       csr_wdata
);

   logic [cpdm_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic [cpdm_pkg::RANGE_W-1:0] limit_ff, limit_in;
   logic                         req_accept;
   logic                         pkt_valid;
   logic                         pkt_take;
   cpdm_pkg::packet_type         pkt;

   // csr writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in   = thr_ff;
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cpdm_pkg::CSR_TILT_THRESHOLD: thr_in   = csr_wdata[cpdm_pkg::THR_W-1:0];
            cpdm_pkg::CSR_OBSTACLE_LIMIT: limit_in = csr_wdata;
            default: begin
               thr_in   = thr_ff;
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= cpdm_pkg::THR_W'(819);
         limit_ff <= cpdm_pkg::RANGE_W'(150);
      end else begin
         thr_ff   <= thr_in;
         limit_ff <= limit_in;
      end
   end

   // the packet register can take a new packet when empty or when it moves on
   assign req_ready  = !pkt_valid || pkt_take;
   assign req_accept = req_valid && req_ready;

   cpdm_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_accept(req_accept),
      .item_type  (req_type),
      .item_byte  (req_data_byte),
      .item_range (req_range_mm),
      .pkt_take   (pkt_take),
      .pkt_valid  (pkt_valid),
      .pkt        (pkt)
   );

   // mixing sits between the packet register and the result register
   cpdm_mixer u_mixer (
      .clock         (clock),
      .reset         (reset),
      .pkt_valid     (pkt_valid),
      .pkt           (pkt),
      .tilt_threshold(thr_ff),
      .obstacle_limit(limit_ff),
      .pkt_take      (pkt_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .left_speed    (rsp_left_speed),
      .right_speed   (rsp_right_speed),
      .source        (rsp_source),
      .obstacle_stop (rsp_obstacle_stop)
   );

endmodule
